FILE: sv/bsa_pkg.sv
// Shared types and constants of the bitmap slot allocator.
// No dependencies; every other file imports this package.
`default_nettype none

package bsa_pkg;

    // Sizing
    localparam int MAX_SLOTS      = 256;
    localparam int WORD_W         = 64;
    localparam int BM_WORDS       = (MAX_SLOTS + WORD_W - 1) / WORD_W;
    localparam int WORD_IDX_W     = $clog2(BM_WORDS);
    localparam int BIT_IDX_W      = $clog2(WORD_W);
    localparam int SLOT_IDX_W     = WORD_IDX_W + BIT_IDX_W;
    localparam int COUNT_W        = 9;
    localparam int ADDR_W         = 64;
    localparam int SLOT_BYTES_W   = 17;
    localparam int ARENA_W        = 33;
    localparam int PROD_W         = SLOT_IDX_W + SLOT_BYTES_W;
    localparam int DIV_CNT_W      = $clog2(ARENA_W);

    localparam logic [SLOT_BYTES_W-1:0] MIN_SLOT_BYTES = SLOT_BYTES_W'(16);
    localparam logic [COUNT_W-1:0]      MAX_SLOT_COUNT = COUNT_W'(MAX_SLOTS);

    // Request kinds (codes 2 and 3 are both queries)
    localparam logic [1:0] MODE_ALLOC = 2'd0;
    localparam logic [1:0] MODE_FREE  = 2'd1;

    // Result status codes
    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_FULL      = 2'd1;
    localparam logic [1:0] STATUS_NOT_ALLOC = 2'd2;

    // Configuration register indexes
    localparam logic [1:0] CFG_BASE_ADDRESS = 2'd0;
    localparam logic [1:0] CFG_SLOT_BYTES   = 2'd1;
    localparam logic [1:0] CFG_SLOT_COUNT   = 2'd2;
    localparam logic [1:0] CFG_ARENA_BYTES  = 2'd3;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RANGE,
        ST_DIV,
        ST_LOOKUP,
        ST_SCAN,
        ST_ADDR,
        ST_DONE
    } bsa_state_t;

    // Bitmap update command
    typedef struct packed {
        logic                  set;
        logic                  clr;
        logic [SLOT_IDX_W-1:0] idx;
    } bsa_bm_cmd_t;

endpackage

`default_nettype wire

FILE: sv/bsa_divider.sv
// Restoring divider, one quotient bit per cycle, for address-to-slot mapping.
// Depends on bsa_pkg.
`default_nettype none

module bsa_divider (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             go,
    input  wire logic [bsa_pkg::ARENA_W-1:0]      dividend,
    input  wire logic [bsa_pkg::SLOT_BYTES_W-1:0] divisor,
    output logic                                  finished,
    output logic [bsa_pkg::ARENA_W-1:0]           quotient,
    output logic [bsa_pkg::SLOT_BYTES_W-1:0]      remainder
);
    import bsa_pkg::*;

    logic                    run_reg, run_next;
    logic                    fin_reg, fin_next;
    logic [DIV_CNT_W-1:0]    cnt_reg, cnt_next;
    logic [ARENA_W-1:0]      q_reg, q_next;
    logic [SLOT_BYTES_W-1:0] r_reg, r_next;
    logic [SLOT_BYTES_W-1:0] d_reg, d_next;
    logic [SLOT_BYTES_W:0]   trial;
    logic [SLOT_BYTES_W:0]   diff;
    logic                    fits;

    // One restoring step: shift in the next dividend bit, try a subtract
    assign trial = {r_reg, q_reg[ARENA_W-1]};
    assign diff  = trial - {1'b0, d_reg};
    assign fits  = trial >= {1'b0, d_reg};

    always_comb
    begin
        run_next = run_reg;
        fin_next = 1'b0;
        cnt_next = cnt_reg;
        q_next   = q_reg;
        r_next   = r_reg;
        d_next   = d_reg;
        if (go)
        begin
            run_next = 1'b1;
            cnt_next = '0;
            q_next   = dividend;
            r_next   = '0;
            d_next   = divisor;
        end
        else if (run_reg)
        begin
            q_next = {q_reg[ARENA_W-2:0], fits};
            r_next = fits ? diff[SLOT_BYTES_W-1:0] : trial[SLOT_BYTES_W-1:0];
            if (cnt_reg == DIV_CNT_W'(ARENA_W - 1))
            begin
                run_next = 1'b0;
                fin_next = 1'b1;
            end
            else
            begin
                cnt_next = cnt_reg + 1'b1;
            end
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg <= 1'b0;
            fin_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            run_reg <= run_next;
            fin_reg <= fin_next;
            cnt_reg <= cnt_next;
        end
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
        r_reg <= r_next;
        d_reg <= d_next;
    end

    assign finished  = fin_reg;
    assign quotient  = q_reg;
    assign remainder = r_reg;

endmodule

`default_nettype wire

FILE: sv/bsa_bitmap.sv
// Used-slot bitmap, MSB-first words, with one read port and a free-slot search.
// Depends on bsa_pkg.
`default_nettype none

module bsa_bitmap (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire bsa_pkg::bsa_bm_cmd_t            cmd,
    input  wire logic [bsa_pkg::SLOT_IDX_W-1:0]  rd_idx,
    input  wire logic [bsa_pkg::COUNT_W-1:0]     limit,
    output logic                                 scan_found,
    output logic [bsa_pkg::BIT_IDX_W-1:0]        scan_pos,
    output logic                                 rd_bit
);
    import bsa_pkg::*;

    logic [WORD_W-1:0]     bitmap_reg [BM_WORDS];
    logic [WORD_W-1:0]     rd_word;
    logic [WORD_IDX_W-1:0] rd_w;
    logic [WORD_IDX_W-1:0] wr_w;
    logic [BIT_IDX_W-1:0]  wr_b;
    logic [WORD_W-1:0]     free_vec;

    assign rd_w    = rd_idx[SLOT_IDX_W-1:BIT_IDX_W];
    assign rd_word = bitmap_reg[rd_w];
    assign rd_bit  = rd_word[BIT_IDX_W'(WORD_W - 1) - rd_idx[BIT_IDX_W-1:0]];

    assign wr_w = cmd.idx[SLOT_IDX_W-1:BIT_IDX_W];
    assign wr_b = BIT_IDX_W'(WORD_W - 1) - cmd.idx[BIT_IDX_W-1:0];

    // Free slots of the selected word that lie below the slot limit
    always_comb
    begin
        for (int k = 0; k < WORD_W; k++)
        begin
            free_vec[k] = !rd_word[WORD_W - 1 - k]
                          && ({1'b0, rd_w, BIT_IDX_W'(k)} < {{(SLOT_IDX_W + 1 - COUNT_W){1'b0}}, limit});
        end
    end

    // Lowest free position in the word
    always_comb
    begin
        scan_found = 1'b0;
        scan_pos   = '0;
        for (int k = WORD_W - 1; k >= 0; k--)
        begin
            if (free_vec[k])
            begin
                scan_found = 1'b1;
                scan_pos   = BIT_IDX_W'(k);
            end
        end
    end

    // Bit updates
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int w = 0; w < BM_WORDS; w++)
            begin
                bitmap_reg[w] <= '0;
            end
        end
        else if (cmd.set)
        begin
            bitmap_reg[wr_w][wr_b] <= 1'b1;
        end
        else if (cmd.clr)
        begin
            bitmap_reg[wr_w][wr_b] <= 1'b0;
        end
    end

endmodule

`default_nettype wire

FILE: sv/bitmap_slot_allocator_unit.sv
// Top level of the bitmap slot allocator: config registers, sequencer, results.
// Depends on bsa_pkg, bsa_bitmap and bsa_divider.
//
//   channel   handshake            payload
//   request   start / busy         mode, address
//   result    done (1-cycle beat)  status, slot_address, slot_number,
//                                  is_allocated, live_slots, arena_released
//   config    cfg_write            cfg_index, cfg_data
//
// Allocate: one bitmap word searched per cycle, then the slot address is formed.
// Free and query: range check, then the bit-serial divider and a bitmap lookup
// when the address lies in the arena; otherwise straight to done.
// busy is high from the cycle after accept up to and including the done cycle.
// Reset clears the bitmap and live count at once; no clearing pass.
// Results cannot be stalled: each beat is shown for one cycle only.
`default_nettype none

module bitmap_slot_allocator_unit (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [1:0]  mode,
    input  wire logic [63:0] address,
    output logic             done,
    output logic [1:0]       status,
    output logic [63:0]      slot_address,
    output logic [7:0]       slot_number,
    output logic             is_allocated,
    output logic [8:0]       live_slots,
    output logic             arena_released,
    input  wire logic        cfg_write,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [63:0] cfg_data
);
    import bsa_pkg::*;

    // Configuration
    logic [ADDR_W-1:0]       base_reg;
    logic [SLOT_BYTES_W-1:0] sbytes_reg;
    logic [COUNT_W-1:0]      scount_reg;
    logic [ARENA_W-1:0]      arena_reg;
    logic [SLOT_BYTES_W-1:0] eff_bytes;
    logic [COUNT_W-1:0]      eff_count;

    // Sequencer and request
    bsa_state_t              state_reg, state_next;
    logic [1:0]              mode_reg, mode_next;
    logic [ADDR_W-1:0]       addr_reg, addr_next;
    logic [WORD_IDX_W-1:0]   wcnt_reg, wcnt_next;
    logic [PROD_W-1:0]       prod_reg, prod_next;
    logic [COUNT_W-1:0]      live_reg, live_next;

    // Result registers
    logic [1:0]              status_reg, status_next;
    logic [ADDR_W-1:0]       saddr_reg, saddr_next;
    logic [SLOT_IDX_W-1:0]   snum_reg, snum_next;
    logic                    alloc_reg, alloc_next;
    logic                    rel_reg, rel_next;

    // Datapath nets
    logic                    accept;
    logic                    is_free_req;
    logic [ADDR_W-1:0]       offset;
    logic                    in_range;
    logic                    div_go;
    logic                    div_fin;
    logic [ARENA_W-1:0]      div_quot;
    logic [SLOT_BYTES_W-1:0] div_rem;
    logic                    is_slot;
    logic [SLOT_IDX_W-1:0]   rd_idx;
    logic                    scan_found;
    logic [BIT_IDX_W-1:0]    scan_pos;
    logic                    rd_bit;
    logic [SLOT_IDX_W-1:0]   found_idx;
    logic [COUNT_W-1:0]      live_dec;
    bsa_bm_cmd_t             bm_cmd;

    assign eff_bytes = (sbytes_reg < MIN_SLOT_BYTES) ? MIN_SLOT_BYTES : sbytes_reg;
    assign eff_count = (scount_reg > MAX_SLOT_COUNT) ? MAX_SLOT_COUNT : scount_reg;

    assign accept       = start && (state_reg == ST_IDLE);
    assign is_free_req  = (mode_reg == MODE_FREE);

    // Arena range check on the latched address
    assign offset   = addr_reg - base_reg;
    assign in_range = (addr_reg >= base_reg)
                      && (offset < {{(ADDR_W - ARENA_W){1'b0}}, arena_reg});
    assign div_go   = (state_reg == ST_RANGE) && in_range;

    // Slot test after the division
    assign is_slot = (div_rem == '0)
                     && (div_quot < {{(ARENA_W - COUNT_W){1'b0}}, eff_count});

    assign rd_idx    = (state_reg == ST_SCAN) ? {wcnt_reg, {BIT_IDX_W{1'b0}}}
                                              : div_quot[SLOT_IDX_W-1:0];
    assign found_idx = {wcnt_reg, scan_pos};
    assign live_dec  = live_reg - 1'b1;

    bsa_divider u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .go        (div_go),
        .dividend  (offset[ARENA_W-1:0]),
        .divisor   (eff_bytes),
        .finished  (div_fin),
        .quotient  (div_quot),
        .remainder (div_rem)
    );

    bsa_bitmap u_bm (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (bm_cmd),
        .rd_idx     (rd_idx),
        .limit      (eff_count),
        .scan_found (scan_found),
        .scan_pos   (scan_pos),
        .rd_bit     (rd_bit)
    );

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = (mode == MODE_ALLOC) ? ST_SCAN : ST_RANGE;
                end
            end
            ST_RANGE:
            begin
                state_next = in_range ? ST_DIV : ST_DONE;
            end
            ST_DIV:
            begin
                if (div_fin)
                begin
                    state_next = ST_LOOKUP;
                end
            end
            ST_LOOKUP:
            begin
                state_next = ST_DONE;
            end
            ST_SCAN:
            begin
                if (scan_found)
                begin
                    state_next = ST_ADDR;
                end
                else if (wcnt_reg == WORD_IDX_W'(BM_WORDS - 1))
                begin
                    state_next = ST_DONE;
                end
            end
            ST_ADDR:
            begin
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Datapath and result updates
    always_comb
    begin
        mode_next   = mode_reg;
        addr_next   = addr_reg;
        wcnt_next   = wcnt_reg;
        prod_next   = prod_reg;
        live_next   = live_reg;
        status_next = status_reg;
        saddr_next  = saddr_reg;
        snum_next   = snum_reg;
        alloc_next  = alloc_reg;
        rel_next    = rel_reg;
        bm_cmd      = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    mode_next   = mode;
                    addr_next   = address;
                    wcnt_next   = '0;
                    status_next = STATUS_OK;
                    saddr_next  = '0;
                    snum_next   = '0;
                    alloc_next  = 1'b0;
                    rel_next    = 1'b0;
                end
            end
            ST_RANGE:
            begin
                if (!in_range && is_free_req)
                begin
                    status_next = STATUS_NOT_ALLOC;
                end
            end
            ST_LOOKUP:
            begin
                if (!is_slot)
                begin
                    if (is_free_req)
                    begin
                        status_next = STATUS_NOT_ALLOC;
                    end
                end
                else
                begin
                    snum_next = div_quot[SLOT_IDX_W-1:0];
                    if (is_free_req)
                    begin
                        if (rd_bit)
                        begin
                            bm_cmd.clr = 1'b1;
                            bm_cmd.idx = div_quot[SLOT_IDX_W-1:0];
                            live_next  = live_dec;
                            rel_next   = (live_dec == '0);
                        end
                        else
                        begin
                            status_next = STATUS_NOT_ALLOC;
                        end
                    end
                    else
                    begin
                        alloc_next = rd_bit;
                    end
                end
            end
            ST_SCAN:
            begin
                if (scan_found)
                begin
                    bm_cmd.set = 1'b1;
                    bm_cmd.idx = found_idx;
                    live_next  = live_reg + 1'b1;
                    snum_next  = found_idx;
                    prod_next  = PROD_W'(found_idx) * PROD_W'(eff_bytes);
                end
                else if (wcnt_reg == WORD_IDX_W'(BM_WORDS - 1))
                begin
                    status_next = STATUS_FULL;
                end
                else
                begin
                    wcnt_next = wcnt_reg + 1'b1;
                end
            end
            ST_ADDR:
            begin
                saddr_next = base_reg + {{(ADDR_W - PROD_W){1'b0}}, prod_reg};
            end
            default:
            begin
            end
        endcase
    end

    // Control state and configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            live_reg   <= '0;
            base_reg   <= '0;
            sbytes_reg <= SLOT_BYTES_W'(16);
            scount_reg <= COUNT_W'(256);
            arena_reg  <= ARENA_W'(4096);
        end
        else
        begin
            state_reg <= state_next;
            live_reg  <= live_next;
            if (cfg_write)
            begin
                case (cfg_index)
                    CFG_BASE_ADDRESS: base_reg   <= cfg_data;
                    CFG_SLOT_BYTES:   sbytes_reg <= cfg_data[SLOT_BYTES_W-1:0];
                    CFG_SLOT_COUNT:   scount_reg <= cfg_data[COUNT_W-1:0];
                    CFG_ARENA_BYTES:  arena_reg  <= cfg_data[ARENA_W-1:0];
                    default:          base_reg   <= base_reg;
                endcase
            end
        end
    end

    // Request and result payload
    always_ff @(posedge clk)
    begin
        mode_reg   <= mode_next;
        addr_reg   <= addr_next;
        wcnt_reg   <= wcnt_next;
        prod_reg   <= prod_next;
        status_reg <= status_next;
        saddr_reg  <= saddr_next;
        snum_reg   <= snum_next;
        alloc_reg  <= alloc_next;
        rel_reg    <= rel_next;
    end

    // Outputs
    always_comb
    begin
        busy           = (state_reg != ST_IDLE);
        done           = (state_reg == ST_DONE);
        status         = status_reg;
        slot_address   = saddr_reg;
        slot_number    = snum_reg;
        is_allocated   = alloc_reg;
        live_slots     = live_reg;
        arena_released = rel_reg;
    end

endmodule

`default_nettype wire

FILE: sv/bsa_checker.sv
// Port-level checks for the bitmap slot allocator, bound to the top level.
// Depends on bsa_pkg and bitmap_slot_allocator_unit.
`default_nettype none

module bsa_checker (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic        busy,
    input  wire logic        done,
    input  wire logic [1:0]  status,
    input  wire logic [63:0] slot_address,
    input  wire logic [7:0]  slot_number,
    input  wire logic        is_allocated,
    input  wire logic [8:0]  live_slots,
    input  wire logic        arena_released
);
    import bsa_pkg::*;

    // An accepted request keeps the block busy on the next cycle
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("accepted request did not raise busy");

    // A result beat is a single-cycle pulse, shown while busy
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> busy ##1 !done)
        else $error("result beat longer than one cycle or outside busy");

    // A full arena grants nothing
    a_full_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && status == STATUS_FULL |-> slot_address == '0 && slot_number == '0)
        else $error("full arena reported a slot");

    // Release only on a successful free that empties the arena
    a_release: assert property (@(posedge clk) disable iff (!rst_n)
        done && arena_released |-> live_slots == '0 && status == STATUS_OK
                                   && !is_allocated)
        else $error("arena released with live slots or bad status");

endmodule

bind bitmap_slot_allocator_unit bsa_checker u_bsa_checker (.*);

`default_nettype wire

FILE: tb/sv/tb_bitmap_slot_allocator_unit.sv
// Testbench for bitmap_slot_allocator_unit: directed and random allocate, free and
// query beats checked field by field against a behavioural bitmap model.
// Depends on bsa_pkg and the allocator RTL; self-contained otherwise.
module tb_bitmap_slot_allocator_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import bsa_pkg::*;

    // Query codes not named in the package
    localparam logic [1:0] MODE_QUERY = 2'd2;
    localparam logic [1:0] MODE_SPARE = 2'd3;

    localparam int unsigned CYCLE_LIMIT  = 400000;
    localparam int unsigned DRAIN_CYCLES = 50;
    localparam int unsigned RANDOM_ITEMS = 800;

    typedef struct packed {
        logic [1:0]  status;
        logic [63:0] slot_address;
        logic [7:0]  slot_number;
        logic        is_allocated;
        logic [8:0]  live_slots;
        logic        arena_released;
    } outcome_t;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        start     = 1'b0;
    logic [1:0]  mode      = MODE_ALLOC;
    logic [63:0] address   = '0;
    logic        cfg_write = 1'b0;
    logic [1:0]  cfg_index = CFG_BASE_ADDRESS;
    logic [63:0] cfg_data  = '0;
    logic        busy;
    logic        done;
    logic [1:0]  status;
    logic [63:0] slot_address;
    logic [7:0]  slot_number;
    logic        is_allocated;
    logic [8:0]  live_slots;
    logic        arena_released;

    // Model of the arena: bitmap, live count and register mirror
    logic [63:0] used_map [BM_WORDS];
    logic [8:0]  live_model;
    logic [63:0] cfg_base;
    logic [16:0] cfg_slot_bytes;
    logic [8:0]  cfg_slot_count;
    logic [32:0] cfg_arena_bytes;

    outcome_t    expected_outcomes [$];
    int unsigned fail_count  = 0;
    int unsigned cycle_count = 0;

    bitmap_slot_allocator_unit i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .mode           (mode),
        .address        (address),
        .done           (done),
        .status         (status),
        .slot_address   (slot_address),
        .slot_number    (slot_number),
        .is_allocated   (is_allocated),
        .live_slots     (live_slots),
        .arena_released (arena_released),
        .cfg_write      (cfg_write),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    always #6 clk = ~clk;

    // Run watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    function automatic void reset_model();
        for (int w = 0; w < BM_WORDS; w++)
        begin
            used_map[w] = '0;
        end
        live_model      = '0;
        cfg_base        = '0;
        cfg_slot_bytes  = 17'd16;
        cfg_slot_count  = 9'd256;
        cfg_arena_bytes = 33'd4096;
    endfunction

    // Slot size as used: anything under the minimum counts as the minimum
    function automatic logic [63:0] slot_size();
        return (cfg_slot_bytes < MIN_SLOT_BYTES) ? 64'(MIN_SLOT_BYTES) : 64'(cfg_slot_bytes);
    endfunction

    function automatic int unsigned slot_limit();
        return (cfg_slot_count > MAX_SLOT_COUNT) ? MAX_SLOTS : int'(cfg_slot_count);
    endfunction

    // Slot i sits in word i/64, most significant bit first
    function automatic logic slot_taken(input int unsigned i);
        return used_map[i / WORD_W][WORD_W - 1 - (i % WORD_W)];
    endfunction

    // Address to slot index: in range, aligned and below the slot count
    function automatic bit locate_slot(input logic [63:0] addr, output int unsigned idx);
        logic [63:0] sz;
        logic [63:0] off;
        logic [63:0] q;
        idx = 0;
        sz  = slot_size();
        if (addr < cfg_base)
            return 1'b0;
        off = addr - cfg_base;
        if (off >= 64'(cfg_arena_bytes))
            return 1'b0;
        if (off % sz != 64'd0)
            return 1'b0;
        q = off / sz;
        if (q >= 64'(slot_limit()))
            return 1'b0;
        idx = int'(q);
        return 1'b1;
    endfunction

    // Applies one request to the model and returns the beat it should produce
    function automatic outcome_t apply_request(input logic [1:0] kind, input logic [63:0] addr);
        outcome_t    r;
        int unsigned idx;
        bit          hit;
        r   = '0;
        idx = 0;
        hit = 1'b0;
        if (kind == MODE_ALLOC)
        begin
            for (int unsigned i = 0; i < slot_limit(); i++)
            begin
                if (!slot_taken(i))
                begin
                    idx = i;
                    hit = 1'b1;
                    break;
                end
            end
            if (hit)
            begin
                used_map[idx / WORD_W][WORD_W - 1 - (idx % WORD_W)] = 1'b1;
                live_model     = live_model + 9'd1;
                r.slot_address = cfg_base + 64'(idx) * slot_size();
                r.slot_number  = idx[7:0];
            end
            else
            begin
                r.status = STATUS_FULL;
            end
        end
        else if (kind == MODE_FREE)
        begin
            if (locate_slot(addr, idx))
            begin
                r.slot_number = idx[7:0];
                if (slot_taken(idx))
                begin
                    used_map[idx / WORD_W][WORD_W - 1 - (idx % WORD_W)] = 1'b0;
                    live_model       = live_model - 9'd1;
                    r.arena_released = (live_model == 9'd0);
                end
                else
                begin
                    r.status = STATUS_NOT_ALLOC;
                end
            end
            else
            begin
                r.status = STATUS_NOT_ALLOC;
            end
        end
        else if (locate_slot(addr, idx))
        begin
            // query, spare code behaves the same
            r.slot_number  = idx[7:0];
            r.is_allocated = slot_taken(idx);
        end
        r.live_slots = live_model;
        return r;
    endfunction

    function automatic void compare_field(input string field, input logic [63:0] want,
                                          input logic [63:0] got);
        if (want !== got)
        begin
            $error("%s: expected %0h, actual %0h", field, want, got);
            fail_count++;
        end
    endfunction

    // Result checker: every done beat against the oldest expectation
    always @(posedge clk)
    begin : result_check
        outcome_t want;
        if (rst_n && done)
        begin
            if (expected_outcomes.size() == 0)
            begin
                $error("result beat with nothing outstanding: status %0h slot %0h",
                       status, slot_number);
                fail_count++;
            end
            else
            begin
                want = expected_outcomes.pop_front();
                compare_field("status", 64'(want.status), 64'(status));
                compare_field("slot_address", want.slot_address, slot_address);
                compare_field("slot_number", 64'(want.slot_number), 64'(slot_number));
                compare_field("is_allocated", 64'(want.is_allocated), 64'(is_allocated));
                compare_field("live_slots", 64'(want.live_slots), 64'(live_slots));
                compare_field("arena_released", 64'(want.arena_released),
                              64'(arena_released));
            end
        end
    end

    // Sends one beat; start is left high so back-to-back beats need no gap
    task automatic issue_request(input logic [1:0] kind, input logic [63:0] addr);
        start   <= 1'b1;
        mode    <= kind;
        address <= addr;
        do
            @(posedge clk);
        while (busy);
        expected_outcomes.push_back(apply_request(kind, addr));
    endtask

    task automatic pause_sender();
        start <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk);
    endtask

    // Drop start and wait until every beat is back and the block is idle
    task automatic wait_idle();
        start <= 1'b0;
        @(posedge clk);
        while (expected_outcomes.size() != 0 || busy)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [63:0] data);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
    endtask

    // Reprogram all four registers; the bitmap carries over on purpose
    task automatic load_arena(input logic [63:0] base, input logic [16:0] bytes,
                              input logic [8:0] count, input logic [32:0] span);
        wait_idle();
        write_reg(CFG_BASE_ADDRESS, base);
        write_reg(CFG_SLOT_BYTES, 64'(bytes));
        write_reg(CFG_SLOT_COUNT, 64'(count));
        write_reg(CFG_ARENA_BYTES, 64'(span));
        cfg_write       <= 1'b0;
        cfg_base        = base;
        cfg_slot_bytes  = bytes;
        cfg_slot_count  = count;
        cfg_arena_bytes = span;
    endtask

    // Reset values: base 0, 16-byte slots, 256 slots, 4 KiB arena
    task automatic test_default_arena();
        issue_request(MODE_QUERY, 64'd0);
        issue_request(MODE_ALLOC, '1);
        issue_request(MODE_ALLOC, 64'd0);
        issue_request(MODE_QUERY, 64'd16);
        issue_request(MODE_SPARE, 64'd16);
        issue_request(MODE_QUERY, 64'd24);     // misaligned
        issue_request(MODE_FREE, 64'd8);       // misaligned free
        issue_request(MODE_FREE, 64'd32);      // slot never taken
        issue_request(MODE_QUERY, 64'd4096);   // just past the arena
        issue_request(MODE_FREE, 64'd16);
        issue_request(MODE_FREE, 64'd0);       // arena empties
    endtask

    // Arena at the top of the address space: grant address wraps, then full
    task automatic test_wrap_and_full();
        load_arena(64'hFFFF_FFFF_FFFF_FFE0, 17'd0, 9'd3, 33'h1_0000_0000);
        issue_request(MODE_ALLOC, 64'd0);
        issue_request(MODE_ALLOC, 64'd0);
        issue_request(MODE_ALLOC, 64'd0);
        issue_request(MODE_ALLOC, 64'd0);
        issue_request(MODE_QUERY, 64'd0);      // below base
        issue_request(MODE_FREE, 64'hFFFF_FFFF_FFFF_FFF0);
        issue_request(MODE_FREE, 64'hFFFF_FFFF_FFFF_FFF0);   // already free
    endtask

    // Zero count, oversized count, one-byte arena, then a shrunk count
    task automatic test_count_extremes();
        load_arena(64'd0, 17'd65536, 9'd0, 33'h1_0000_0000);
        issue_request(MODE_ALLOC, 64'd0);
        load_arena(64'h1000, 17'd15, 9'd300, 33'd1);
        issue_request(MODE_ALLOC, 64'd0);
        issue_request(MODE_QUERY, 64'h1000);
        issue_request(MODE_QUERY, 64'h1010);
        load_arena(64'h1000, 17'd16, 9'd1, 33'd4096);
        issue_request(MODE_FREE, 64'h1010);    // above the count
        issue_request(MODE_QUERY, 64'h1010);
        issue_request(MODE_FREE, 64'h1000);
    endtask

    function automatic logic [1:0] pick_mode();
        int unsigned r;
        r = $urandom_range(0, 19);
        if (r < 8)
            return MODE_ALLOC;
        else if (r < 14)
            return MODE_FREE;
        else if (r < 19)
            return MODE_QUERY;
        return MODE_SPARE;
    endfunction

    // Mostly slot-aligned addresses near the count, plus misses of every kind
    function automatic logic [63:0] pick_address();
        logic [63:0] sz;
        sz = slot_size();
        case ($urandom_range(0, 9))
            0: return {$urandom, $urandom};
            1: return cfg_base - 64'($urandom_range(1, 64));
            2: return cfg_base + 64'(cfg_arena_bytes);
            3: return cfg_base + 64'($urandom_range(0, slot_limit())) * sz
                      + 64'($urandom_range(1, int'(sz) - 1));
            default: return cfg_base + 64'($urandom_range(0, slot_limit())) * sz;
        endcase
    endfunction

    task automatic test_random_traffic(input int unsigned item_target);
        int unsigned sent;
        int unsigned phase_len;
        bit          phase_idles;
        logic [63:0] base;
        logic [16:0] bytes;
        logic [8:0]  count;
        logic [32:0] span;
        logic [32:0] used_span;
        sent = 0;
        while (sent < item_target)
        begin
            case ($urandom_range(0, 3))
                0: base = '0;
                1: base = {$urandom, $urandom};
                2: base = 64'hFFFF_FFFF_FFFF_FFFF - 64'($urandom_range(0, 4095));
                default: base = {32'd0, $urandom & 32'hFFFF_FFF0};
            endcase
            case ($urandom_range(0, 5))
                0: bytes = 17'($urandom_range(0, 16));
                1, 2: bytes = 17'($urandom_range(16, 256));
                3: bytes = 17'($urandom_range(16, 65536));
                4: bytes = 17'd65536;
                default: bytes = 17'd16;
            endcase
            case ($urandom_range(0, 9))
                0: count = 9'd0;
                1: count = 9'd256;
                2: count = 9'($urandom_range(257, 511));
                default: count = 9'($urandom_range(1, 12));
            endcase
            used_span = 33'((bytes < MIN_SLOT_BYTES) ? MIN_SLOT_BYTES : bytes)
                        * 33'((count > MAX_SLOT_COUNT) ? MAX_SLOT_COUNT : count);
            case ($urandom_range(0, 4))
                0: span = 33'($urandom_range(1, 64));
                1: span = 33'h1_0000_0000;
                2: span = {1'($urandom_range(0, 1)), $urandom};
                default: span = used_span - 33'($urandom_range(0, 1)) + 33'($urandom_range(0, 1));
            endcase
            if (span == 33'd0)
                span = 33'd1;
            load_arena(base, bytes, count, span);

            phase_len   = $urandom_range(30, 90);
            phase_idles = ($urandom_range(0, 3) != 0);
            for (int unsigned n = 0; n < phase_len && sent < item_target; n++)
            begin
                issue_request(pick_mode(), pick_address());
                sent++;
                // no gaps over the last stretch of the run
                if (phase_idles && sent + 100 < item_target && $urandom_range(0, 2) == 0)
                    pause_sender();
            end
        end
    endtask

    initial
    begin
        reset_model();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_default_arena();
        test_wrap_and_full();
        test_count_extremes();
        test_random_traffic(RANDOM_ITEMS);

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
